[rtl/dpst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense Prim spanning tree package
// Shared widths, codes and types of the dense Prim spanning tree unit.
// ----------------------------------------------------------------------------
package dpst_pkg;

    localparam int VERTICES     = 8;
    localparam int VIDX_W       = $clog2(VERTICES);
    localparam int CNT_W        = VIDX_W + 1;
    localparam int MAT_DEPTH    = VERTICES * VERTICES;
    localparam int MAT_AW       = 2 * VIDX_W;
    localparam int WEIGHT_BITS  = 16;
    localparam int KEY_W        = WEIGHT_BITS + 1;
    localparam int TOTAL_W      = 19;
    localparam int NUM_W        = 4;
    localparam int MIN_VERTICES = 2;

    localparam logic [KEY_W-1:0] KEY_INF = {KEY_W{1'b1}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VIDX_W-1:0] parent;
        logic              in_tree;
    } vstate_t;

    typedef struct packed {
        logic              load;
        logic              clear;
        logic [VIDX_W-1:0] child;
        logic [VIDX_W-1:0] parent;
        logic [KEY_W-1:0]  key;
        logic              last;
    } emit_req_t;

endpackage

[rtl/dpst_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel that carries matrix loads and run commands.
// ----------------------------------------------------------------------------
interface dpst_in_if
    import dpst_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [VIDX_W-1:0]      row;
    logic [VIDX_W-1:0]      col;
    logic [WEIGHT_BITS-1:0] weight;

    modport source (output valid, output op, output row, output col, output weight,
                    input ready);
    modport sink (input valid, input op, input row, input col, input weight,
                  output ready);
endinterface

[rtl/dpst_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel that carries one tree edge per transaction.
// ----------------------------------------------------------------------------
interface dpst_out_if
    import dpst_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic [VIDX_W-1:0]      parent_vertex;
    logic [VIDX_W-1:0]      child_vertex;
    logic [WEIGHT_BITS-1:0] edge_weight;
    logic [TOTAL_W-1:0]     running_total;
    logic                   reachable;
    logic                   last;

    modport source (output valid, output parent_vertex, output child_vertex,
                    output edge_weight, output running_total, output reachable,
                    output last, input ready);
    modport sink (input valid, input parent_vertex, input child_vertex,
                  input edge_weight, input running_total, input reachable,
                  input last, output ready);
endinterface

[rtl/dpst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dpst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/dpst_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge result stage
// Formats one tree edge, keeps the running total and holds the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
module dpst_emit
    import dpst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  emit_req_t          req,
    dpst_out_if.source         out_ch
);

    logic                   valid_reg;
    logic [VIDX_W-1:0]      parent_reg;
    logic [VIDX_W-1:0]      child_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   reach_reg;
    logic                   last_reg;

    logic                   reach_next;
    logic [WEIGHT_BITS-1:0] weight_next;
    logic [TOTAL_W-1:0]     total_next;

    always_comb
    begin
        reach_next  = (req.key != KEY_INF);
        weight_next = reach_next ? req.key[WEIGHT_BITS-1:0] : '0;
        total_next  = (req.clear ? '0 : total_reg)
                      + {{(TOTAL_W-WEIGHT_BITS){1'b0}}, weight_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            reach_reg  <= reach_next;
            parent_reg <= reach_next ? req.parent : '0;
            child_reg  <= req.child;
            weight_reg <= weight_next;
            total_reg  <= total_next;
            last_reg   <= req.last;
        end
    end

    assign out_ch.valid         = valid_reg;
    assign out_ch.parent_vertex = parent_reg;
    assign out_ch.child_vertex  = child_reg;
    assign out_ch.edge_weight   = weight_reg;
    assign out_ch.running_total = total_reg;
    assign out_ch.reachable     = reach_reg;
    assign out_ch.last          = last_reg;

endmodule

[rtl/dense_prim_spanning_tree_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dense Prim spanning tree unit
// Grows a minimum spanning tree from vertex 0 over a dense weight matrix.
// ----------------------------------------------------------------------------
// Usage: in_ch carries load transactions (op = 0), which write one matrix
// weight, and run transactions (op = 1). A load is accepted whenever the
// unit is idle, so loads stream one per cycle while it is idle. A run
// clears the vertex state memory, then for each of up to n-1 steps scans
// the vertex memory for the least key, marks the winner and relaxes its
// matrix row, all through the registered read port of each memory.
// out_ch then carries one transaction per child vertex 1..n-1, each one
// loaded only after the previous one is taken; the last is marked. in_ch
// is not ready while a run or its results are in progress. A stalled
// receiver holds the output register and the sequencer waits. Reset
// returns to idle, sets num_vertices to 8 and leaves the matrix undefined
// until written. cfg_we/cfg_wdata write num_vertices; the user must use
// them only while the unit is idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module dense_prim_spanning_tree_unit
    import dpst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [NUM_W-1:0] cfg_wdata,
    dpst_in_if.sink          in_ch,
    dpst_out_if.source       out_ch
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INIT  = 3'd1;
    localparam logic [2:0] S_SRCH  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_RELAX = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OLD   = 3'd6;
    localparam logic [2:0] S_OWT   = 3'd7;

    localparam logic [CNT_W-1:0] CNT_LAST_INIT = CNT_W'(VERTICES - 1);
    localparam logic [NUM_W-1:0] NUM_MIN       = NUM_W'(MIN_VERTICES);
    localparam logic [NUM_W-1:0] NUM_MAX       = NUM_W'(VERTICES);

    logic [2:0]        state_reg, state_next;
    logic [NUM_W-1:0]  num_reg;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  step_reg, step_next;
    logic              p1_valid_reg, p1_valid_next;
    logic [VIDX_W-1:0] p1_idx_reg, p1_idx_next;
    logic [VIDX_W-1:0] u_reg, u_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [VIDX_W-1:0] best_par_reg, best_par_next;
    logic              found_reg, found_next;

    logic              mat_we;
    logic [MAT_AW-1:0] mat_waddr;
    logic [MAT_AW-1:0] mat_raddr;
    logic [WEIGHT_BITS-1:0] mat_rdata;

    logic              v_we;
    logic [VIDX_W-1:0] v_waddr;
    vstate_t           v_wdata;
    logic [VIDX_W-1:0] v_raddr;
    vstate_t           v_rdata;

    logic [CNT_W-1:0]  n_clamped;
    logic              in_fire;
    logic              out_fire;
    emit_req_t         req;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign out_fire    = out_ch.valid && out_ch.ready;

    always_comb
    begin
        if (num_reg < NUM_MIN)
        begin
            n_clamped = CNT_W'(NUM_MIN);
        end
        else if (num_reg > NUM_MAX)
        begin
            n_clamped = CNT_W'(NUM_MAX);
        end
        else
        begin
            n_clamped = CNT_W'(num_reg);
        end
    end

    assign mat_we    = in_fire && (in_ch.op == OP_LOAD);
    assign mat_waddr = {in_ch.row, in_ch.col};
    assign mat_raddr = {u_reg, cnt_reg[VIDX_W-1:0]};

    dpst_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAT_DEPTH)
    ) u_mat_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr (mat_waddr),
        .wdata (in_ch.weight),
        .raddr (mat_raddr),
        .rdata (mat_rdata)
    );

    dpst_ram #(
        .WIDTH ($bits(vstate_t)),
        .DEPTH (VERTICES)
    ) u_vtx_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        step_next     = step_reg;
        p1_valid_next = 1'b0;
        p1_idx_next   = p1_idx_reg;
        u_next        = u_reg;
        best_key_next = best_key_reg;
        best_par_next = best_par_reg;
        found_next    = found_reg;
        v_we          = 1'b0;
        v_waddr       = cnt_reg[VIDX_W-1:0];
        v_wdata       = '{key: KEY_INF, parent: '0, in_tree: 1'b0};
        v_raddr       = cnt_reg[VIDX_W-1:0];
        req           = '{load: 1'b0, clear: 1'b0, child: cnt_reg[VIDX_W-1:0],
                          parent: v_rdata.parent, key: v_rdata.key,
                          last: (cnt_reg + 1'b1 == n_reg)};

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_ch.op == OP_RUN))
                begin
                    n_next     = n_clamped;
                    cnt_next   = '0;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                v_we    = 1'b1;
                v_wdata = '{key: (cnt_reg == '0) ? '0 : KEY_INF, parent: '0,
                            in_tree: 1'b0};
                if (cnt_reg == CNT_LAST_INIT)
                begin
                    step_next     = '0;
                    cnt_next      = '0;
                    best_key_next = KEY_INF;
                    found_next    = 1'b0;
                    state_next    = S_SRCH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SRCH:
            begin
                if (cnt_reg < n_reg)
                begin
                    p1_valid_next = 1'b1;
                    p1_idx_next   = cnt_reg[VIDX_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                if (p1_valid_reg)
                begin
                    if (!v_rdata.in_tree && (v_rdata.key < best_key_reg))
                    begin
                        best_key_next = v_rdata.key;
                        best_par_next = v_rdata.parent;
                        u_next        = p1_idx_reg;
                        found_next    = 1'b1;
                    end
                end
                else if (cnt_reg == n_reg)
                begin
                    if (found_reg)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        cnt_next   = CNT_W'(1);
                        state_next = S_ORD;
                    end
                end
            end
            S_MARK:
            begin
                v_we       = 1'b1;
                v_waddr    = u_reg;
                v_wdata    = '{key: best_key_reg, parent: best_par_reg, in_tree: 1'b1};
                step_next  = step_reg + 1'b1;
                cnt_next   = '0;
                state_next = S_RELAX;
            end
            S_RELAX:
            begin
                if (cnt_reg < n_reg)
                begin
                    p1_valid_next = 1'b1;
                    p1_idx_next   = cnt_reg[VIDX_W-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
                if (p1_valid_reg)
                begin
                    v_waddr = p1_idx_reg;
                    v_wdata = '{key: {1'b0, mat_rdata}, parent: u_reg, in_tree: 1'b0};
                    v_we    = (mat_rdata != '0) && !v_rdata.in_tree
                              && ({1'b0, mat_rdata} < v_rdata.key);
                end
                else if (cnt_reg == n_reg)
                begin
                    if (step_reg + 1'b1 < n_reg)
                    begin
                        cnt_next      = '0;
                        best_key_next = KEY_INF;
                        found_next    = 1'b0;
                        state_next    = S_SRCH;
                    end
                    else
                    begin
                        cnt_next   = CNT_W'(1);
                        state_next = S_ORD;
                    end
                end
            end
            S_ORD:
            begin
                state_next = S_OLD;
            end
            S_OLD:
            begin
                req.load   = 1'b1;
                req.clear  = (cnt_reg == CNT_W'(1));
                state_next = S_OWT;
            end
            S_OWT:
            begin
                if (out_fire)
                begin
                    if (cnt_reg + 1'b1 == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            num_reg      <= NUM_W'(VERTICES);
            n_reg        <= CNT_W'(VERTICES);
            cnt_reg      <= '0;
            step_reg     <= '0;
            p1_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            cnt_reg      <= cnt_next;
            step_reg     <= step_next;
            p1_valid_reg <= p1_valid_next;
            found_reg    <= found_next;
            if (cfg_we)
            begin
                num_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg   <= p1_idx_next;
        u_reg        <= u_next;
        best_key_reg <= best_key_next;
        best_par_reg <= best_par_next;
    end

    dpst_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .out_ch (out_ch)
    );

endmodule
